// ===== hw/rtl/tc8_pkg.sv =====
// Shared types, codes and helpers for the 8-bit prescaled timer/counter.
`default_nettype none
package tc8_pkg;

    localparam int COUNT_W    = 8;
    localparam int PRESCALE_W = 10;

    typedef enum logic [1:0] {
        CMD_TICK           = 2'd0,
        CMD_WRITE_COUNT    = 2'd1,
        CMD_CLEAR_FLAG     = 2'd2,
        CMD_RESET_PRESCALE = 2'd3
    } tc8_cmd_t;

    typedef enum logic [2:0] {
        CS_STOP    = 3'd0,
        CS_DIV1    = 3'd1,
        CS_DIV8    = 3'd2,
        CS_DIV64   = 3'd3,
        CS_DIV256  = 3'd4,
        CS_DIV1024 = 3'd5,
        CS_T0_FALL = 3'd6,
        CS_T0_RISE = 3'd7
    } tc8_clk_sel_t;

    typedef struct packed {
        logic [COUNT_W-1:0]    counter;
        logic                  overflow_sticky;
        logic [PRESCALE_W-1:0] prescale_count;
        logic                  previous_pin;
    } tc8_state_t;

    function automatic logic [PRESCALE_W-1:0] divisor_mask(input tc8_clk_sel_t sel);
        logic [PRESCALE_W-1:0] mask;
        case (sel)
            CS_DIV1:   mask = PRESCALE_W'(0);
            CS_DIV8:   mask = PRESCALE_W'(8 - 1);
            CS_DIV64:  mask = PRESCALE_W'(64 - 1);
            CS_DIV256: mask = PRESCALE_W'(256 - 1);
            default:   mask = PRESCALE_W'(1024 - 1);
        endcase
        return mask;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tc8_core.sv =====
// Next-state and result logic of the timer/counter for one transfer.
`default_nettype none
module tc8_core
    import tc8_pkg::*;
#(
    parameter int DELAY = 2
) (
    input  tc8_cmd_t           cmd,
    input  logic               t0_level,
    input  logic [COUNT_W-1:0] write_value,
    input  tc8_clk_sel_t       clk_sel,
    input  tc8_state_t         state,
    input  logic [DELAY-1:0]   delay_line,
    output tc8_state_t         state_next,
    output logic [DELAY-1:0]   delay_line_next,
    output logic               overflow_event
);

    logic                  edge_seen;
    logic                  delayed;
    logic [DELAY:0]        shifted;
    logic [PRESCALE_W-1:0] prescale_inc;
    logic                  advance;
    logic                  wrap;

    always_comb begin
        case (clk_sel)
            CS_T0_FALL: edge_seen = state.previous_pin & ~t0_level;
            CS_T0_RISE: edge_seen = ~state.previous_pin & t0_level;
            default:    edge_seen = 1'b0;
        endcase
    end

    assign delayed      = delay_line[DELAY-1];
    assign shifted      = {delay_line, edge_seen};
    assign prescale_inc = state.prescale_count + PRESCALE_W'(1);
    assign wrap         = (state.counter == {COUNT_W{1'b1}});

    always_comb begin
        advance = 1'b0;
        case (clk_sel) inside
            [CS_DIV1:CS_DIV1024]: advance = ((prescale_inc & divisor_mask(clk_sel)) == '0);
            CS_T0_FALL, CS_T0_RISE: advance = delayed;
            default: advance = 1'b0;
        endcase
    end

    always_comb begin
        state_next      = state;
        delay_line_next = delay_line;
        overflow_event  = 1'b0;
        case (cmd)
            CMD_WRITE_COUNT:    state_next.counter = write_value;
            CMD_CLEAR_FLAG:     state_next.overflow_sticky = 1'b0;
            CMD_RESET_PRESCALE: state_next.prescale_count = '0;
            default: begin
                state_next.previous_pin = t0_level;
                delay_line_next         = shifted[DELAY-1:0];
                if (clk_sel inside {[CS_DIV1:CS_DIV1024]}) begin
                    state_next.prescale_count = prescale_inc;
                end
                if (advance) begin
                    state_next.counter = state.counter + COUNT_W'(1);
                    if (wrap) begin
                        state_next.overflow_sticky = 1'b1;
                        overflow_event             = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/timer_counter_8bit_prescaled_top.sv =====
// Top level of the 8-bit timer/counter with prescaler and T0 edge input.
//
//  channel  | dir | handshake           | payload
//  s_       | in  | s_tvalid/s_tready   | tuser: cmd; tdata: t0_level, write_value
//  m_       | out | m_tvalid/m_tready   | tdata: count, overflow_flag, overflow_event
//  cfg_     | in  | cfg_valid/cfg_ready | cfg_data: clock_select
//
// One input transfer per cycle while no result is stalled; its result is registered
// on acceptance. The state update and result are one combinational pass from the
// state registers. A stalled result holds s_tready low only while m_tready is low.
// Synchronous active-low reset clears all state but m_tdata; cfg is always ready.
`default_nettype none
module timer_counter_8bit_prescaled_top
    import tc8_pkg::*;
#(
    parameter int DELAY = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [0] t0_level, [8:1] write_value, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] count, [8] overflow_flag, [9] overflow_event
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data
);

    tc8_clk_sel_t     clk_sel_reg;
    tc8_state_t       state_reg;
    tc8_state_t       state_next;
    logic [DELAY-1:0] delay_line_reg;
    logic [DELAY-1:0] delay_line_next;
    logic             event_next;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic             s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign s_accept  = s_tvalid & s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    tc8_core #(
        .DELAY(DELAY)
    ) u_core (
        .cmd            (tc8_cmd_t'(s_tuser)),
        .t0_level       (s_tdata[0]),
        .write_value    (s_tdata[8:1]),
        .clk_sel        (clk_sel_reg),
        .state          (state_reg),
        .delay_line     (delay_line_reg),
        .state_next     (state_next),
        .delay_line_next(delay_line_next),
        .overflow_event (event_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_sel_reg    <= CS_STOP;
            state_reg      <= '0;
            delay_line_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                clk_sel_reg <= tc8_clk_sel_t'(cfg_data);
            end
            if (s_accept) begin
                state_reg      <= state_next;
                delay_line_reg <= delay_line_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {6'd0, event_next, state_next.overflow_sticky, state_next.counter};
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tc8_checker.sv =====
// Port-level checks for the timer/counter top level, bound to it.
`default_nettype none
module tc8_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_event_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[8])
        else $error("overflow event without sticky flag");

    a_event_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[7:0] == 8'd0)
        else $error("overflow event with nonzero count");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind timer_counter_8bit_prescaled_top tc8_checker u_tc8_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire
